>>> hw/rtl/keypad_click_autorepeat_assert.svh
// assertion macros for the keypad click and autorepeat block
`ifndef KEYPAD_CLICK_AUTOREPEAT_ASSERT_SVH
`define KEYPAD_CLICK_AUTOREPEAT_ASSERT_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define KCA_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kca assertion failed");
// condition that must never hold outside reset
`define KCA_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("kca forbidden condition seen");
`else
`define KCA_ASSERT(name, clk, rstn, prop)
`define KCA_ASSERT_NEVER(name, clk, rstn, cond)
`endif

`endif

>>> hw/rtl/kca_pkg.sv
// types, key table and helpers shared by the keypad click and autorepeat block
`default_nettype none

package kca_pkg;

  localparam int unsigned KEY_COUNT = 13;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned SHOOT_W   = 2;
  localparam int unsigned PANEL_W   = 12;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DELAY_W   = 16;

  localparam logic [KEY_W-1:0] KEY_NONE = '0;
  localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(KEY_COUNT);

  localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST   = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RST = 16'd175;

  typedef enum logic [0:0] {
    CFG_INITIAL_DELAY   = 1'b0,
    CFG_REPEAT_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef logic [KEY_COUNT-1:0] key_vec_t;

  // key table in priority order: group select and the lines that must all be low
  localparam logic [KEY_COUNT-1:0] KEY_ON_PANEL = 13'b1_1111_0001_1111;
  localparam logic [PANEL_W-1:0] KEY_MASK [KEY_COUNT] = '{
    12'h010, 12'h040, 12'h080, 12'h020, 12'h100,
    12'h003, 12'h002, 12'h001,
    12'h004, 12'h008, 12'h200, 12'h400, 12'h800
  };

  typedef struct packed {
    key_vec_t         down;
    logic [KEY_W-1:0] pressed;
    logic [KEY_W-1:0] clicked;
  } keys_t;

  function automatic key_vec_t key_down_vec(input logic [SHOOT_W-1:0] shoot,
                                            input logic [PANEL_W-1:0] panel);
    key_vec_t vec;
    logic [PANEL_W-1:0] lines;
    for (int k = 0; k < KEY_COUNT; k++) begin
      lines  = KEY_ON_PANEL[k] ? panel : {{(PANEL_W-SHOOT_W){1'b0}}, shoot};
      vec[k] = ((lines & KEY_MASK[k]) == '0);
    end
    return vec;
  endfunction

  // 1-based index of the lowest set bit, 0 when none is set
  function automatic logic [KEY_W-1:0] first_key(input key_vec_t vec);
    logic [KEY_W-1:0] idx;
    idx = KEY_NONE;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (vec[k]) idx = KEY_W'(k + 1);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kca_keys.sv
// key decode: pressed vector, first pressed key and first clicked key
`default_nettype none

module kca_keys (
  input  logic [kca_pkg::SHOOT_W-1:0] shoot_i,
  input  logic [kca_pkg::PANEL_W-1:0] panel_i,
  input  logic [kca_pkg::SHOOT_W-1:0] prev_shoot_i,
  input  logic [kca_pkg::PANEL_W-1:0] prev_panel_i,
  output kca_pkg::keys_t              keys_o
);
  import kca_pkg::*;

  key_vec_t down_now;
  key_vec_t down_prev;

  always_comb begin
    down_now  = key_down_vec(shoot_i, panel_i);
    down_prev = key_down_vec(prev_shoot_i, prev_panel_i);
    keys_o.down    = down_now;
    keys_o.pressed = first_key(down_now);
    // released last scan, pressed now
    keys_o.clicked = first_key(down_now & ~down_prev);
  end

endmodule

`default_nettype wire

>>> hw/rtl/kca_repeat.sv
// autorepeat state, line history and delay registers
`default_nettype none

module kca_repeat (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [kca_pkg::DELAY_W-1:0] cfg_data_i,
  input  logic                        step_i,
  input  logic                        mode_i,
  input  logic [kca_pkg::SHOOT_W-1:0] shoot_i,
  input  logic [kca_pkg::PANEL_W-1:0] panel_i,
  input  logic [kca_pkg::TIME_W-1:0]  time_i,
  input  kca_pkg::keys_t              keys_i,
  output logic [kca_pkg::SHOOT_W-1:0] prev_shoot_o,
  output logic [kca_pkg::PANEL_W-1:0] prev_panel_o,
  output logic [kca_pkg::KEY_W-1:0]   pressed_o,
  output logic [kca_pkg::KEY_W-1:0]   clicked_o,
  output logic [kca_pkg::KEY_W-1:0]   repeat_o
);
  import kca_pkg::*;

  `include "keypad_click_autorepeat_assert.svh"

  logic [DELAY_W-1:0] init_delay_q, interval_q;
  logic [SHOOT_W-1:0] prev_shoot_q, prev_shoot_d;
  logic [PANEL_W-1:0] prev_panel_q, prev_panel_d;
  logic [KEY_W-1:0]   held_key_q, held_key_d;
  logic [TIME_W-1:0]  held_since_q, held_since_d;
  logic               repeating_q, repeating_d;

  logic [KEY_W-1:0]   held_idx;
  logic               held_down;
  logic [DELAY_W-1:0] limit;
  logic [TIME_W-1:0]  elapsed;
  logic               fire;
  logic [KEY_W-1:0]   rep;
  cfg_idx_e           cfg_sel;

  assign cfg_sel = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_delay_q <= INITIAL_DELAY_RST;
      interval_q   <= REPEAT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_sel)
        CFG_INITIAL_DELAY:   init_delay_q <= cfg_data_i;
        CFG_REPEAT_INTERVAL: interval_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_idx  = held_key_q - KEY_W'(1);
    held_down = 1'b0;
    if (held_key_q != KEY_NONE && held_key_q <= KEY_LAST) begin
      held_down = keys_i.down[held_idx];
    end
    limit   = repeating_q ? interval_q : init_delay_q;
    elapsed = time_i - held_since_q;
    // negative elapsed time never repeats
    fire    = !elapsed[TIME_W-1] && (elapsed > {{(TIME_W-DELAY_W){1'b0}}, limit});
  end

  always_comb begin
    prev_shoot_d = prev_shoot_q;
    prev_panel_d = prev_panel_q;
    held_key_d   = held_key_q;
    held_since_d = held_since_q;
    repeating_d  = repeating_q;
    rep          = KEY_NONE;
    if (mode_i) begin
      held_key_d = KEY_NONE;
    end else begin
      prev_shoot_d = shoot_i;
      prev_panel_d = panel_i;
      if (keys_i.clicked != KEY_NONE) begin
        held_key_d   = keys_i.clicked;
        repeating_d  = 1'b0;
        held_since_d = time_i;
        rep          = keys_i.clicked;
      end else if (held_down) begin
        if (fire) begin
          repeating_d  = 1'b1;
          held_since_d = time_i;
          rep          = held_key_q;
        end
      end else begin
        held_key_d = KEY_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_shoot_q <= '0;
      prev_panel_q <= '0;
      held_key_q   <= KEY_NONE;
      held_since_q <= '0;
      repeating_q  <= 1'b0;
    end else if (step_i) begin
      prev_shoot_q <= prev_shoot_d;
      prev_panel_q <= prev_panel_d;
      held_key_q   <= held_key_d;
      held_since_q <= held_since_d;
      repeating_q  <= repeating_d;
    end
  end

  assign prev_shoot_o = prev_shoot_q;
  assign prev_panel_o = prev_panel_q;
  assign pressed_o    = mode_i ? KEY_NONE : keys_i.pressed;
  assign clicked_o    = mode_i ? KEY_NONE : keys_i.clicked;
  assign repeat_o     = rep;

  `KCA_ASSERT_NEVER(held_range_a, clk_i, rst_ni, held_key_q > KEY_LAST)
  `KCA_ASSERT(clear_held_a, clk_i, rst_ni, (step_i && mode_i) |=> (held_key_q == KEY_NONE))
  `KCA_ASSERT(rep_sets_held_a, clk_i, rst_ni, (step_i && rep != KEY_NONE) |=> (held_key_q == $past(rep)))
  `KCA_ASSERT(click_wins_a, clk_i, rst_ni, (step_i && clicked_o != KEY_NONE) |-> (repeat_o == clicked_o))

endmodule

`default_nettype wire

>>> hw/rtl/keypad_click_autorepeat.sv
// top level of the keypad click and autorepeat block
//
//  port group   dir  tdata / tuser layout (lsb first)          words
//  s_axis       in   tdata: shoot_lines[1:0], panel_lines[13:2], one scan sample
//                    time_ms[45:14], zero pad; tuser: mode
//  m_axis       out  tdata: pressed_key[3:0], clicked_key[7:4],   one result per scan
//                    repeat_key[11:8], zero pad
//  cfg          in   cfg_idx_i 0 initial delay, 1 repeat interval
//
// each word passes through the input register, then the key decode and repeat logic that
// feeds the output register; one word per cycle while m_axis_tready stays high
// the 32-bit elapsed-time subtract and compare sets the cycle time
// reset clears the line history, the held key and the input and output valid; delays
// return to 500 and 175 ms
// while a result waits with m_axis_tready low the output register holds, the input
// register still takes a word if empty, and s_axis_tready drops once it is also full
`default_nettype none

module keypad_click_autorepeat (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // shoot_lines, panel_lines, time_ms, pad
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // pressed_key, clicked_key, repeat_key, pad
);
  import kca_pkg::*;

  // input register
  logic               in_valid_q;
  logic               in_mode_q;
  logic [SHOOT_W-1:0] in_shoot_q;
  logic [PANEL_W-1:0] in_panel_q;
  logic [TIME_W-1:0]  in_time_q;

  // output register
  logic               out_valid_q;
  logic [KEY_W-1:0]   out_pressed_q, out_clicked_q, out_repeat_q;

  logic               advance;
  logic               step;
  logic               accept;
  keys_t              keys;
  logic [SHOOT_W-1:0] prev_shoot;
  logic [PANEL_W-1:0] prev_panel;
  logic [KEY_W-1:0]   pressed, clicked, repeat_key;

  // output slot frees up when empty or being taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_mode_q  <= s_axis_tuser;
      in_shoot_q <= s_axis_tdata[1:0];
      in_panel_q <= s_axis_tdata[13:2];
      in_time_q  <= s_axis_tdata[45:14];
    end
  end

  kca_keys u_keys (
    .shoot_i      (in_shoot_q),
    .panel_i      (in_panel_q),
    .prev_shoot_i (prev_shoot),
    .prev_panel_i (prev_panel),
    .keys_o       (keys)
  );

  kca_repeat u_repeat (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .step_i       (step),
    .mode_i       (in_mode_q),
    .shoot_i      (in_shoot_q),
    .panel_i      (in_panel_q),
    .time_i       (in_time_q),
    .keys_i       (keys),
    .prev_shoot_o (prev_shoot),
    .prev_panel_o (prev_panel),
    .pressed_o    (pressed),
    .clicked_o    (clicked),
    .repeat_o     (repeat_key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_pressed_q <= pressed;
      out_clicked_q <= clicked;
      out_repeat_q  <= repeat_key;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_repeat_q, out_clicked_q, out_pressed_q};

endmodule

`default_nettype wire

>>> dv/keypad_click_autorepeat_test.sv
// self-checking testbench for the keypad click and autorepeat block
`timescale 1ns / 100ps

module keypad_click_autorepeat_test;
  import kca_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int LIMIT_CYCLES   = 400_000;   // watchdog, far above the slowest legal run
  localparam int RAND_PER_PHASE = 135;       // random scan words per delay setting
  localparam int LONG_HOLD      = 64;        // receiver hold-off used to back up the pipe
  localparam int SETTLE_CYCLES  = 6;         // two-stage pipe plus margin
  localparam int MAX_REPORTS    = 10;

  // scan word mode codes
  localparam bit MODE_SCAN  = 1'b0;
  localparam bit MODE_CLEAR = 1'b1;

  typedef struct {
    bit                 mode;
    logic [SHOOT_W-1:0] shoot;
    logic [PANEL_W-1:0] panel;
    logic [TIME_W-1:0]  tick;
  } scan_t;

  typedef struct {
    logic [KEY_W-1:0] pressed;
    logic [KEY_W-1:0] clicked;
    logic [KEY_W-1:0] rpt;
  } keys_word_t;

  // expected key words, worked out from the scans the block accepted
  class keypad_scoreboard;
    logic [DELAY_W-1:0] delay_ms;
    logic [DELAY_W-1:0] interval_ms;
    logic [SHOOT_W-1:0] last_shoot;
    logic [PANEL_W-1:0] last_panel;
    logic [KEY_W-1:0]   held;
    logic [TIME_W-1:0]  held_tick;
    bit                 repeating;
    keys_word_t         expected_q[$];
    int                 errors;
    int                 checked;
    int                 scans;
    int                 clicks;
    int                 repeats;
    int                 clears;

    function new();
      delay_ms    = INITIAL_DELAY_RST;
      interval_ms = REPEAT_INTERVAL_RST;
      last_shoot  = '0;
      last_panel  = '0;
      held        = KEY_NONE;
      held_tick   = '0;
      repeating   = 1'b0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [DELAY_W-1:0] val);
      if (idx == CFG_INITIAL_DELAY) delay_ms = val;
      else interval_ms = val;
    endfunction

    function bit key_is_down(int k, logic [SHOOT_W-1:0] shoot, logic [PANEL_W-1:0] panel);
      logic [PANEL_W-1:0] lines;
      lines = KEY_ON_PANEL[k] ? panel : {{(PANEL_W-SHOOT_W){1'b0}}, shoot};
      return (lines & KEY_MASK[k]) == '0;
    endfunction

    function void note_scan(scan_t s);
      keys_word_t         w;
      logic [TIME_W-1:0]  elapsed;
      logic [DELAY_W-1:0] limit;
      w.pressed = KEY_NONE;
      w.clicked = KEY_NONE;
      w.rpt     = KEY_NONE;
      scans++;
      if (s.mode == MODE_CLEAR) begin
        held = KEY_NONE;
        clears++;
        expected_q.push_back(w);
        return;
      end
      for (int k = 0; k < KEY_COUNT; k++) begin
        if (w.pressed == KEY_NONE && key_is_down(k, s.shoot, s.panel))
          w.pressed = KEY_W'(k + 1);
        if (w.clicked == KEY_NONE && !key_is_down(k, last_shoot, last_panel) &&
            key_is_down(k, s.shoot, s.panel))
          w.clicked = KEY_W'(k + 1);
      end
      if (w.clicked != KEY_NONE) begin
        held      = w.clicked;
        repeating = 1'b0;
        held_tick = s.tick;
        w.rpt     = w.clicked;
        clicks++;
      end else if (held != KEY_NONE && held <= KEY_LAST &&
                   key_is_down(int'(held) - 1, s.shoot, s.panel)) begin
        elapsed = s.tick - held_tick;
        limit   = repeating ? interval_ms : delay_ms;
        if (!elapsed[TIME_W-1] && elapsed > {{(TIME_W-DELAY_W){1'b0}}, limit}) begin
          repeating = 1'b1;
          held_tick = s.tick;
          w.rpt     = held;
          repeats++;
        end
      end else begin
        held = KEY_NONE;
      end
      last_shoot = s.shoot;
      last_panel = s.panel;
      expected_q.push_back(w);
    endfunction

    function void check_word(logic [15:0] tdata);
      keys_word_t got;
      keys_word_t want;
      got.pressed = tdata[3:0];
      got.clicked = tdata[7:4];
      got.rpt     = tdata[11:8];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected key word, got pressed %0d clicked %0d repeat %0d",
                   $realtime, got.pressed, got.clicked, got.rpt);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.pressed !== want.pressed || got.clicked !== want.clicked ||
          got.rpt !== want.rpt) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: key word %0d mismatch, expected %0d/%0d/%0d got %0d/%0d/%0d",
                   $realtime, checked, want.pressed, want.clicked, want.rpt,
                   got.pressed, got.clicked, got.rpt);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // shoot_lines, panel_lines, time_ms, pad
  logic        s_axis_tuser  = 1'b0; // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // pressed_key, clicked_key, repeat_key, pad

  keypad_scoreboard sb = new();

  bit                idle_en   = 1'b1;  // random gaps on both sides
  bit                send_gaps = 1'b1;  // sender side gaps, off while backing up the pipe
  bit                hold_req  = 1'b0;  // asks the receiver for one long hold-off
  int                sent      = 0;
  logic [TIME_W-1:0] tick      = '0;    // running millisecond stamp for the next scan

  keypad_click_autorepeat i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timeout with %0d key words still expected", sb.expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: checks each accepted key word, then picks tready for the next edge
  // values read right after the edge are the ones the block saw at that edge
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) sb.check_word(m_axis_tdata);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      // no leftover gap once idling is off
      if (!idle_en) stall_left = 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (stall_left == 0 && idle_en && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 17);
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // offer one scan word and wait for the handshake; the prediction is noted on acceptance
  // every driving task is entered and left right after a rising edge
  task automatic send_scan(input scan_t s);
    if (idle_en && send_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, s.tick, s.panel, s.shoot};
    s_axis_tuser  <= s.mode;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_scan(s);
    sent++;
  endtask

  task automatic send_lines(input bit mode, input logic [SHOOT_W-1:0] shoot,
                            input logic [PANEL_W-1:0] panel, input logic [TIME_W-1:0] stamp);
    scan_t s;
    s.mode  = mode;
    s.shoot = shoot;
    s.panel = panel;
    s.tick  = stamp;
    send_scan(s);
  endtask

  // registers are to be written only while idle: no word in flight, pipe flushed; the block itself does not enforce it
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register write, with the write enable dropped again before the task returns
  task automatic write_reg(input cfg_idx_e idx, input logic [DELAY_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // active-low lines with one table key down (0 for none), unused panel bits random,
  // optionally a sparse set of extra lines pulled low
  function automatic void lines_for(input int key, input bit extras,
                                    output logic [SHOOT_W-1:0] shoot,
                                    output logic [PANEL_W-1:0] panel);
    shoot      = '1;
    panel      = '1;
    panel[1:0] = 2'($urandom);
    if (extras) begin
      panel &= ~PANEL_W'($urandom & $urandom & $urandom);
      shoot &= ~SHOOT_W'($urandom & $urandom);
    end
    if (key > 0) begin
      if (KEY_ON_PANEL[key-1]) panel &= ~KEY_MASK[key-1];
      else shoot &= ~KEY_MASK[key-1][SHOOT_W-1:0];
    end
  endfunction

  // time steps cluster around the current delays so the strict compare is hit from both sides
  function automatic logic [TIME_W-1:0] next_step();
    logic [TIME_W-1:0] d;
    logic [TIME_W-1:0] iv;
    d  = TIME_W'(sb.delay_ms);
    iv = TIME_W'(sb.interval_ms);
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 3);
      1:       return d;
      2:       return d + 1;
      3:       return iv;
      4:       return iv + 1;
      5:       return $urandom_range(0, 2 * d + 2);
      6:       return $urandom_range(0, iv + iv / 2 + 2);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // hand-picked scans at the reset delays of 500 and 175 ms
  task automatic directed_scans();
    logic [SHOOT_W-1:0] sh;
    logic [PANEL_W-1:0] pn;
    // history starts all-low, so nothing can click on the first scan
    send_lines(MODE_SCAN, 2'b11, 12'hfff, 32'd0);
    // every line low: every key clicks, the first in table order wins
    send_lines(MODE_SCAN, 2'b00, 12'h000, 32'd1);
    // shoot lines released, panel lines low but for the unused bits: nothing clicks
    send_lines(MODE_SCAN, 2'b11, 12'h003, 32'd2);
    // each table key on its own, a fresh click unless the key was already down in the scan before
    for (int k = 1; k <= KEY_COUNT; k++) begin
      lines_for(k, 1'b0, sh, pn);
      send_lines(MODE_SCAN, sh, pn, 32'(10 + k));
    end
    // hold the last key across both delays: equal is not enough, one more ms repeats
    lines_for(KEY_COUNT, 1'b0, sh, pn);
    send_lines(MODE_SCAN, sh, pn, 32'd523);
    send_lines(MODE_SCAN, sh, pn, 32'd524);
    send_lines(MODE_SCAN, sh, pn, 32'd699);
    send_lines(MODE_SCAN, sh, pn, 32'd700);
    // stamp going backwards reads as negative elapsed time
    send_lines(MODE_SCAN, sh, pn, 32'd695);
    // clear request drops the autorepeat key, the still-held key gives nothing after
    send_lines(MODE_CLEAR, 2'b00, 12'h000, 32'd1000);
    send_lines(MODE_SCAN, sh, pn, 32'd5000);
    // click right at the top of the tick range, then repeat across the wrap
    send_lines(MODE_SCAN, 2'b11, 12'hfff, 32'hffff_fff0);
    lines_for(2, 1'b0, sh, pn);
    send_lines(MODE_SCAN, sh, pn, 32'hffff_ffff);
    send_lines(MODE_SCAN, sh, pn, 32'd500);
    tick = 32'd600;
  endtask

  // arbitrary lines and stamps, now and then a clear request
  task automatic noise_scan();
    if ($urandom_range(0, 1) == 0) tick = $urandom;
    else tick += next_step();
    send_lines(($urandom_range(0, 5) == 0) ? MODE_CLEAR : MODE_SCAN,
               SHOOT_W'($urandom), PANEL_W'($urandom), tick);
  endtask

  // release, press one key, hold it while time moves, release again
  task automatic key_session();
    int                 key;
    int                 hold_len;
    logic [SHOOT_W-1:0] sh;
    logic [PANEL_W-1:0] pn;
    key      = $urandom_range(1, KEY_COUNT);
    hold_len = $urandom_range(2, 12);
    if ($urandom_range(0, 5) == 0) tick = $urandom;
    repeat ($urandom_range(1, 2)) begin
      lines_for(0, $urandom_range(0, 4) == 0, sh, pn);
      tick += next_step();
      send_lines(MODE_SCAN, sh, pn, tick);
    end
    lines_for(key, $urandom_range(0, 5) == 0, sh, pn);
    tick += $urandom_range(0, 20);
    send_lines(MODE_SCAN, sh, pn, tick);
    for (int i = 0; i < hold_len; i++) begin
      lines_for(key, $urandom_range(0, 5) == 0, sh, pn);
      case ($urandom_range(0, 15))
        0:       send_lines(MODE_CLEAR, sh, pn, tick);
        1: begin
          tick -= $urandom_range(1, 2000);
          send_lines(MODE_SCAN, sh, pn, tick);
        end
        2: begin
          tick = $urandom;
          send_lines(MODE_SCAN, sh, pn, tick);
        end
        default: begin
          tick += next_step();
          send_lines(MODE_SCAN, sh, pn, tick);
        end
      endcase
    end
    lines_for(0, 1'b0, sh, pn);
    tick += next_step();
    send_lines(MODE_SCAN, sh, pn, tick);
  endtask

  // mostly well-formed press/hold/release runs, some pure noise
  task automatic random_scans(input int count);
    int start;
    start = sent;
    while (sent - start < count) begin
      if ($urandom_range(0, 7) == 0) noise_scan();
      else key_session();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset delays
    directed_scans();
    random_scans(RAND_PER_PHASE);
    drain();

    // zero delays: any positive elapsed time repeats
    write_reg(CFG_INITIAL_DELAY, 16'd0);
    write_reg(CFG_REPEAT_INTERVAL, 16'd0);
    // receiver stops for a long stretch while scans keep coming, pipe backs up
    send_gaps = 1'b0;
    hold_req  = 1'b1;
    random_scans(24);
    send_gaps = 1'b1;
    random_scans(RAND_PER_PHASE);
    drain();

    // largest delays
    write_reg(CFG_INITIAL_DELAY, 16'hffff);
    write_reg(CFG_REPEAT_INTERVAL, 16'hffff);
    random_scans(RAND_PER_PHASE);
    drain();

    // small random delays, repeats come often
    write_reg(CFG_INITIAL_DELAY, DELAY_W'($urandom_range(1, 60)));
    write_reg(CFG_REPEAT_INTERVAL, DELAY_W'($urandom_range(0, 30)));
    random_scans(RAND_PER_PHASE);
    drain();

    // last part at full rate on both sides
    write_reg(CFG_REPEAT_INTERVAL, DELAY_W'($urandom_range(0, 5)));
    write_reg(CFG_INITIAL_DELAY, DELAY_W'($urandom_range(0, 9)));
    idle_en = 1'b0;
    random_scans(RAND_PER_PHASE);
    drain();

    $display("covered %0d scans (%0d clear requests) under five delay settings",
             sb.scans, sb.clears);
    $display("checked %0d key words holding %0d clicks and %0d autorepeats, %0d mismatches",
             sb.checked, sb.clicks, sb.repeats, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
